/* hw/rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared constants for the sliding window maximum
// Holds the width and the reset value of the window size register.
// ----------------------------------------------------------------------------
package swm_pkg;

   // window size register
   localparam int CSR_BITS = 7;
   localparam logic [CSR_BITS-1:0] WINDOW_RESET = 7'd3;

endpackage

/* hw/rtl/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell: one stage of the running maximum chain
// Holds the maximum of the last k+1 samples. On each accepted sample it
// takes the larger of that sample and the value of its left neighbor.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] left_value,
   output logic signed [SAMPLE_BITS-1:0] value_out
);

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;

   // take the larger of the new sample and the neighbor's running maximum
   always_comb begin
      value_in = (left_value > sample) ? left_value : sample;
   end

   // advance only on an accepted sample
   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
      end
   end

   assign value_out = value_ff;

endmodule

/* hw/rtl/swm_chain.sv */
// ----------------------------------------------------------------------------
// swm_chain: row of running maximum cells
// Cell k holds the maximum of the last k+1 samples. The cell picked by
// sel_index is offered as the window maximum.
// ----------------------------------------------------------------------------
module swm_chain #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16,
   localparam int IDX_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [IDX_BITS-1:0]    sel_index,
   output logic signed [SAMPLE_BITS-1:0] read_value
);

   logic signed [SAMPLE_BITS-1:0] cell_values [WINDOW_MAX];

   genvar k;
   generate
      for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
         logic signed [SAMPLE_BITS-1:0] left_value;

         // first cell sees only the new sample
         if (k == 0) begin : g_first
            assign left_value = sample;
         end else begin : g_rest
            assign left_value = cell_values[k-1];
         end

         swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock      (clock),
            .advance    (advance),
            .sample     (sample),
            .left_value (left_value),
            .value_out  (cell_values[k])
         );
      end
   endgenerate

   // pick the cell that spans the live part of the window
   assign read_value = cell_values[sel_index];

endmodule

/* hw/rtl/sliding_window_maximum.sv */
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over the most recent samples
// Stream in signed samples, stream out the maximum of the last window_size.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample per word; req_tuser high starts a new sequence
//   with that sample. rsp_* carries one window maximum per sample once the
//   current sequence holds at least window_size samples; earlier samples of
//   a sequence give no word. csr_* writes window_size (0 acts as 1, values
//   above WINDOW_MAX act as WINDOW_MAX); write it only while idle.
//   A sample enters every cycle as long as the result side keeps up: the
//   row of cells updates all running maxima together on each sample. A
//   result reaches rsp through the cells, then the window select into the
//   output register.
//   When the receiver stalls, one result waits in the output register and
//   one more in the cells; req_tready then drops until rsp drains.
//   Reset empties the window, restarts the sequence count and sets
//   window_size to 3. Shrinking the window drops older samples at the next
//   word; growing it does not bring back samples that already left.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_BITS  = 16,
   localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1),
   localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   // sample stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [DATA_BITS-1:0]           req_tdata,  // [SAMPLE_BITS-1:0] sample
   input  logic                           req_tuser,  // [0] start_req
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [DATA_BITS-1:0]           rsp_tdata,  // [SAMPLE_BITS-1:0] window_max
   // window size register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [swm_pkg::CSR_BITS-1:0]   csr_data
);

   logic [swm_pkg::CSR_BITS-1:0]  window_ff;
   logic [CNT_BITS-1:0]           window_eff;
   logic [CNT_BITS-1:0]           live_ff, live_in, live_base;
   logic [CNT_BITS-1:0]           filled_ff, filled_in, filled_base;
   logic                          pend_ff, pend_in;
   logic [IDX_BITS-1:0]           sel_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] chain_value;
   logic                          accept;
   logic                          out_free;
   logic                          emit;

   // window size register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= swm_pkg::WINDOW_RESET;
      end else if (csr_valid) begin
         window_ff <= csr_data;
      end
   end

   // clamp the window into 1..WINDOW_MAX
   always_comb begin
      if (window_ff == '0) begin
         window_eff = CNT_BITS'(1);
      end else if (32'(window_ff) > 32'(WINDOW_MAX)) begin
         window_eff = CNT_BITS'(WINDOW_MAX);
      end else begin
         window_eff = CNT_BITS'(window_ff);
      end
   end

   // handshake: a sample may enter when the pending result can move on
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pend_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign sample     = $signed(req_tdata[SAMPLE_BITS-1:0]);

   // live span: samples still inside the window, never regrown past a cut
   always_comb begin
      live_base = req_tuser ? '0 : live_ff;
      if (live_base >= window_eff) begin
         live_in = window_eff;
      end else begin
         live_in = live_base + CNT_BITS'(1);
      end
   end

   // sequence length, saturating at the largest window
   always_comb begin
      filled_base = req_tuser ? '0 : filled_ff;
      if (filled_base == CNT_BITS'(WINDOW_MAX)) begin
         filled_in = filled_base;
      end else begin
         filled_in = filled_base + CNT_BITS'(1);
      end
      emit = (filled_in >= window_eff);
   end

   // pending flag: the cells hold a result not yet moved to the output
   always_comb begin
      if (accept) begin
         pend_in = emit;
      end else if (out_free) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= '0;
         filled_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (accept) begin
            live_ff   <= live_in;
            filled_ff <= filled_in;
         end
      end
   end

   // cell index for the live span
   always_ff @(posedge clock) begin
      if (accept) begin
         sel_ff <= IDX_BITS'(live_in - CNT_BITS'(1));
      end
   end

   swm_chain #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_chain (
      .clock      (clock),
      .advance    (accept),
      .sample     (sample),
      .sel_index  (sel_ff),
      .read_value (chain_value)
   );

   // output register
   always_comb begin
      if (pend_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && out_free) begin
         rsp_data_ff <= chain_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'($unsigned(rsp_data_ff));

   // checks
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !out_free) |-> !req_tready)
      else $error("sample taken while a result is stuck in the cells");

   a_start_live: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (live_ff == CNT_BITS'(1)))
      else $error("start did not restart the live span");

   a_live_le_filled: assert property (@(posedge clock) disable iff (reset)
      live_ff <= filled_ff)
      else $error("live span longer than the sequence");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_BITS'(WINDOW_MAX))
      else $error("live span beyond the cell row");

   a_pend_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pend_ff == $past(emit)))
      else $error("pending flag does not follow the warm-up decision");

endmodule
